/* rtl/core/ilffa_pkg.sv */
// ----------------------------------------------------------------------------
// ilffa_pkg
// Shared types, codes and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ilffa_pkg;

    localparam int ADDR_W  = 36;
    localparam int WORD_W  = 32;
    localparam int REQ_W   = 16;
    localparam int CHUNK_W = 17;
    localparam int NEED_W  = 17;
    localparam int ST_W    = 2;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [CHUNK_W-1:0] t_chunk;
    typedef logic [NEED_W-1:0]  t_need;
    typedef logic [ST_W-1:0]    t_status;

    localparam logic    OP_ALLOC = 1'b0;
    localparam logic    OP_FREE  = 1'b1;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_OOM  = 2'd1;
    localparam t_status ST_ZERO = 2'd2;

    localparam t_chunk CHUNK_RST   = 17'd4096;
    localparam int     INIT_END    = 4112;
    localparam t_need  MIN_BLOCK   = 17'd16;
    localparam t_word  TAG_PRO     = 32'd9;
    localparam t_word  TAG_INIT    = 32'd4096;
    localparam t_word  TAG_EPI     = 32'd1;
    localparam t_addr  A_PRO_HEAD  = 36'd4;
    localparam t_addr  A_PRO_FOOT  = 36'd8;
    localparam t_addr  A_INIT_HEAD = 36'd12;
    localparam t_addr  A_INIT_FOOT = 36'd4104;
    localparam t_addr  A_INIT_EPI  = 36'd4108;

    typedef enum logic [5:0] {
        S_INIT, S_IDLE,
        S_F0, S_F1, S_F2, S_F3,
        S_FF0, S_FF1,
        S_GR0, S_GR1, S_GR2, S_GR3, S_GR4,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
        S_MA1, S_MA2, S_MB1, S_MB2,
        S_MC1, S_MC2, S_MC3, S_MC4, S_MC5,
        S_MRET,
        S_PB0, S_PB1, S_PS1, S_PS2, S_PS3, S_PS4, S_PS5, S_PS6,
        S_PN1, S_PN2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic  en;
        logic  we;
        t_addr addr;
        t_word wdata;
    } t_mem_req;

    function automatic t_addr size_of(input t_word w);
        return {{(ADDR_W-WORD_W){1'b0}}, w[WORD_W-1:3], 3'b000};
    endfunction

    function automatic t_word tag_of(input t_addr v);
        return {v[WORD_W-1:3], 3'b000};
    endfunction

endpackage

/* rtl/core/implicit_list_first_fit_allocator_unit.sv */
// ----------------------------------------------------------------------------
// implicit_list_first_fit_allocator_unit
// First-fit boundary-tag heap allocator over a single-port word store.
// ----------------------------------------------------------------------------
// One request at a time. After reset the unit writes the initial heap
// layout before it takes a request. A free clears the allocated bit of the
// block and coalesces it with free neighbours. An allocate reads each block
// header visited by the first-fit walk, then places and splits the block,
// and grows the heap before placing when no free block fits. Each step makes
// at most one access to the store port. chunk_bytes is written through its
// own port and is always ready.
module implicit_list_first_fit_allocator_unit #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_opcode,
    input  logic [15:0]          i_request_bytes,
    input  logic [15:0]          i_block_addr,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [15:0]          o_payload_addr,
    output ilffa_pkg::t_status   o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  ilffa_pkg::t_chunk    i_cfg_chunk_bytes
);
    import ilffa_pkg::*;

    localparam int HE_W = $clog2(HEAP_BYTES) + 1;

    t_state           r_state, n_state;
    logic             r_free, n_free;
    t_need            r_need, n_need;
    t_addr            r_p, n_p;
    t_addr            r_t, n_t;
    t_addr            r_sz, n_sz;
    t_word            r_n, n_n;
    t_addr            r_b, n_b;
    t_addr            r_hb, n_hb;
    t_addr            r_a, n_a;
    logic [HE_W-1:0]  r_heap_end, n_heap_end;
    t_chunk           r_chunk;
    logic [2:0]       r_init, n_init;
    logic             r_ov, n_ov;
    logic [15:0]      r_pay, n_pay;
    t_status          r_st, n_st;
    logic [15:0]      r_rpay, n_rpay;
    t_status          r_rst, n_rst;

    t_mem_req         mreq;
    t_word            rdata;
    t_addr            rsz;
    t_addr            ext, gsz, sz2, he;
    t_need            need_c;

    ilffa_store #(.HEAP_BYTES(HEAP_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_req   (mreq),
        .o_rdata (rdata)
    );

    assign rsz            = size_of(rdata);
    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ov;
    assign o_payload_addr = r_pay;
    assign o_status       = r_st;
    assign o_cfg_ready    = 1'b1;

    assign need_c = (i_request_bytes <= 16'd8) ? MIN_BLOCK :
                    ((t_need'(i_request_bytes) + t_need'(15)) & ~t_need'(7));
    assign ext    = (r_need > t_need'(r_chunk)) ? t_addr'(r_need) : t_addr'(r_chunk);
    assign gsz    = ((((ext >> 2) + t_addr'(1)) >> 1) << 3);
    assign he     = t_addr'(r_heap_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init     <= '0;
            r_heap_end <= HE_W'(INIT_END);
            r_chunk    <= CHUNK_RST;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init     <= n_init;
            r_heap_end <= n_heap_end;
            r_ov       <= n_ov;
            if (i_cfg_valid) begin
                r_chunk <= i_cfg_chunk_bytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_free <= n_free;
        r_need <= n_need;
        r_p    <= n_p;
        r_t    <= n_t;
        r_sz   <= n_sz;
        r_n    <= n_n;
        r_b    <= n_b;
        r_hb   <= n_hb;
        r_a    <= n_a;
        r_pay  <= n_pay;
        r_st   <= n_st;
        r_rpay <= n_rpay;
        r_rst  <= n_rst;
    end

    always_comb begin
        n_state    = r_state;
        n_free     = r_free;
        n_need     = r_need;
        n_p        = r_p;
        n_t        = r_t;
        n_sz       = r_sz;
        n_n        = r_n;
        n_b        = r_b;
        n_hb       = r_hb;
        n_a        = r_a;
        n_heap_end = r_heap_end;
        n_init     = r_init;
        n_ov       = r_ov && !i_ready;
        n_pay      = r_pay;
        n_st       = r_st;
        n_rpay     = r_rpay;
        n_rst      = r_rst;
        sz2        = '0;
        mreq       = '0;

        unique case (r_state)
            S_INIT: begin
                mreq.en = 1'b1;
                mreq.we = 1'b1;
                unique case (r_init)
                    3'd0:    begin mreq.addr = '0;          mreq.wdata = '0;       end
                    3'd1:    begin mreq.addr = A_PRO_HEAD;  mreq.wdata = TAG_PRO;  end
                    3'd2:    begin mreq.addr = A_PRO_FOOT;  mreq.wdata = TAG_PRO;  end
                    3'd3:    begin mreq.addr = A_INIT_HEAD; mreq.wdata = TAG_INIT; end
                    3'd4:    begin mreq.addr = A_INIT_FOOT; mreq.wdata = TAG_INIT; end
                    default: begin mreq.addr = A_INIT_EPI;  mreq.wdata = TAG_EPI;  end
                endcase
                n_init = r_init + 3'd1;
                if (r_init == 3'd5) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_free = (i_opcode == OP_FREE);
                    n_need = need_c;
                    n_rpay = '0;
                    n_rst  = ST_OK;
                    if (i_opcode == OP_FREE) begin
                        n_p     = t_addr'(i_block_addr);
                        n_state = S_F0;
                    end else if (i_request_bytes == '0) begin
                        n_rst   = ST_ZERO;
                        n_state = S_DONE;
                    end else begin
                        n_p     = t_addr'(8);
                        n_state = S_FF0;
                    end
                end
            end
            S_F0: begin
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(4);
                n_state   = S_F1;
            end
            S_F1: begin
                n_t        = rsz;
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = r_p - t_addr'(4);
                mreq.wdata = tag_of(rsz);
                n_state    = S_F2;
            end
            S_F2: begin
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(4);
                n_state   = S_F3;
            end
            S_F3: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = r_p + rsz - t_addr'(8);
                mreq.wdata = tag_of(r_t);
                n_state    = S_M0;
            end
            S_FF0: begin
                if (r_p >= he) begin
                    n_state = S_GR0;
                end else begin
                    mreq.en   = 1'b1;
                    mreq.addr = r_p - t_addr'(4);
                    n_state   = S_FF1;
                end
            end
            S_FF1: begin
                if (rsz == '0) begin
                    n_state = S_GR0;
                end else if (!rdata[0] && (t_addr'(r_need) <= rsz)) begin
                    n_state = S_PB0;
                end else begin
                    n_p     = r_p + rsz;
                    n_state = S_FF0;
                end
            end
            S_GR0: begin
                if (he + gsz > t_addr'(HEAP_BYTES)) begin
                    n_rst   = ST_OOM;
                    n_state = S_DONE;
                end else begin
                    n_p        = he;
                    n_t        = gsz;
                    n_heap_end = HE_W'(he + gsz);
                    mreq.en    = 1'b1;
                    mreq.we    = 1'b1;
                    mreq.addr  = he - t_addr'(4);
                    mreq.wdata = gsz[WORD_W-1:0];
                    n_state    = S_GR1;
                end
            end
            S_GR1: begin
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(4);
                n_state   = S_GR2;
            end
            S_GR2: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = r_p + rsz - t_addr'(8);
                mreq.wdata = r_t[WORD_W-1:0];
                n_state    = S_GR3;
            end
            S_GR3: begin
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(4);
                n_state   = S_GR4;
            end
            S_GR4: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = r_p + rsz - t_addr'(4);
                mreq.wdata = TAG_EPI;
                n_state    = S_M0;
            end
            // coalesce around r_p
            S_M0: begin
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(4);
                n_state   = S_M1;
            end
            S_M1: begin
                n_sz      = rsz;
                mreq.en   = 1'b1;
                mreq.addr = r_p + rsz - t_addr'(4);
                n_state   = S_M2;
            end
            S_M2: begin
                n_n       = rdata;
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(8);
                n_state   = S_M3;
            end
            S_M3: begin
                n_b       = r_p - rsz;
                mreq.en   = 1'b1;
                mreq.addr = r_p - rsz - t_addr'(4);
                n_state   = S_M4;
            end
            S_M4: begin
                n_hb      = rsz;
                mreq.en   = 1'b1;
                mreq.addr = r_b + rsz - t_addr'(8);
                n_state   = S_M5;
            end
            S_M5: begin
                priority if (rdata[0] && r_n[0]) begin
                    n_state = S_MRET;
                end else if (rdata[0]) begin
                    sz2        = r_sz + size_of(r_n);
                    n_sz       = sz2;
                    mreq.en    = 1'b1;
                    mreq.we    = 1'b1;
                    mreq.addr  = r_p - t_addr'(4);
                    mreq.wdata = tag_of(sz2);
                    n_state    = S_MA1;
                end else if (r_n[0]) begin
                    sz2        = r_sz + r_hb;
                    n_sz       = sz2;
                    mreq.en    = 1'b1;
                    mreq.we    = 1'b1;
                    mreq.addr  = r_p + r_sz - t_addr'(8);
                    mreq.wdata = tag_of(sz2);
                    n_state    = S_MB1;
                end else begin
                    sz2        = r_sz + r_hb + size_of(r_n);
                    n_sz       = sz2;
                    mreq.en    = 1'b1;
                    mreq.we    = 1'b1;
                    mreq.addr  = r_b - t_addr'(4);
                    mreq.wdata = tag_of(sz2);
                    n_state    = S_MC1;
                end
            end
            S_MA1: begin
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(4);
                n_state   = S_MA2;
            end
            S_MA2: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = r_p + rsz - t_addr'(8);
                mreq.wdata = tag_of(r_sz);
                n_state    = S_MRET;
            end
            S_MB1: begin
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(8);
                n_state   = S_MB2;
            end
            S_MB2: begin
                n_p        = r_p - rsz;
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = r_p - rsz - t_addr'(4);
                mreq.wdata = tag_of(r_sz);
                n_state    = S_MRET;
            end
            S_MC1: begin
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(4);
                n_state   = S_MC2;
            end
            S_MC2: begin
                n_a       = r_p + rsz;
                mreq.en   = 1'b1;
                mreq.addr = r_p + rsz - t_addr'(4);
                n_state   = S_MC3;
            end
            S_MC3: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = r_a + rsz - t_addr'(8);
                mreq.wdata = tag_of(r_sz);
                n_state    = S_MC4;
            end
            S_MC4: begin
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(8);
                n_state   = S_MC5;
            end
            S_MC5: begin
                n_p     = r_p - rsz;
                n_state = S_MRET;
            end
            S_MRET: begin
                n_state = r_free ? S_DONE : S_PB0;
            end
            // place the request in the block at r_p
            S_PB0: begin
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(4);
                n_state   = S_PB1;
            end
            S_PB1: begin
                n_t     = rsz;
                mreq.en = 1'b1;
                mreq.we = 1'b1;
                mreq.addr = r_p - t_addr'(4);
                if ((rsz >= t_addr'(r_need)) &&
                    (rsz - t_addr'(r_need) >= t_addr'(MIN_BLOCK))) begin
                    mreq.wdata = t_word'(r_need) | TAG_EPI;
                    n_state    = S_PS1;
                end else begin
                    mreq.wdata = tag_of(rsz) | TAG_EPI;
                    n_state    = S_PN1;
                end
            end
            S_PS1: begin
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(4);
                n_state   = S_PS2;
            end
            S_PS2: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = r_p + rsz - t_addr'(8);
                mreq.wdata = t_word'(r_need) | TAG_EPI;
                n_state    = S_PS3;
            end
            S_PS3: begin
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(4);
                n_state   = S_PS4;
            end
            S_PS4: begin
                n_a        = r_p + rsz;
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = r_p + rsz - t_addr'(4);
                mreq.wdata = r_t[WORD_W-1:0] - t_word'(r_need);
                n_state    = S_PS5;
            end
            S_PS5: begin
                mreq.en   = 1'b1;
                mreq.addr = r_a - t_addr'(4);
                n_state   = S_PS6;
            end
            S_PS6: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = r_a + rsz - t_addr'(8);
                mreq.wdata = r_t[WORD_W-1:0] - t_word'(r_need);
                n_rpay     = r_p[15:0];
                n_state    = S_DONE;
            end
            S_PN1: begin
                mreq.en   = 1'b1;
                mreq.addr = r_p - t_addr'(4);
                n_state   = S_PN2;
            end
            S_PN2: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = r_p + rsz - t_addr'(8);
                mreq.wdata = tag_of(r_t) | TAG_EPI;
                n_rpay     = r_p[15:0];
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || i_ready) begin
                    n_ov    = 1'b1;
                    n_pay   = r_rpay;
                    n_st    = r_rst;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/ilffa_store.sv */
// ----------------------------------------------------------------------------
// ilffa_store
// Single-port word store addressed by byte offset; reads outside the heap
// return zero and writes there are dropped. Read data is registered.
// ----------------------------------------------------------------------------
module ilffa_store #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic               i_clk,
    input  ilffa_pkg::t_mem_req i_req,
    output ilffa_pkg::t_word    o_rdata
);
    import ilffa_pkg::*;

    localparam int DEPTH = HEAP_BYTES / 4;
    localparam int IDX_W = $clog2(DEPTH);

    t_word             mem [DEPTH];
    t_word             r_rdata;
    logic              r_inside;
    logic              in_heap;
    logic [IDX_W-1:0]  idx;

    assign in_heap = !i_req.addr[ADDR_W-1] && (i_req.addr < t_addr'(HEAP_BYTES));
    assign idx     = i_req.addr[IDX_W+1:2];
    assign o_rdata = r_inside ? r_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (i_req.en && i_req.we && in_heap) begin
            mem[idx] <= i_req.wdata;
        end
        if (i_req.en && !i_req.we) begin
            r_rdata  <= mem[idx];
        end
        r_inside <= i_req.en && !i_req.we && in_heap;
    end

endmodule
